// ----- rtl/sha_pkg.sv -----
// sha_pkg: types, round constants and helpers for the streaming SHA-256 block.
// No dependencies.
package sha_pkg;

	localparam logic [31:0] RoundK [64] = '{
		32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
		32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
		32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
		32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
		32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
		32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
		32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
		32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
		32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
		32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
		32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
		32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
		32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
		32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
		32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
		32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
	};

	localparam logic [31:0] InitHash [8] = '{
		32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
		32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
	};

	localparam logic [7:0] PadByte = 8'h80;
	localparam logic [5:0] LenPos = 6'd56;
	localparam logic [2:0] MaxBytes = 3'd4;

	typedef struct packed {
		logic       re;
		logic [2:0] raddr;
		logic       we;
		logic [2:0] waddr;
		logic       clr;
	} hm_ctl_t;

	typedef struct packed {
		logic       re;
		logic [3:0] raddr;
		logic       we;
		logic [3:0] waddr;
		logic [1:0] lane;
	} bf_ctl_t;

	function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
		rotr = (x >> n) | (x << (32 - n));
	endfunction

endpackage

// ----- rtl/sha_if.sv -----
// sha_in_if / sha_out_if: valid/ready channels for message words and digest words.
// No dependencies.
interface sha_in_if;
	logic        valid;
	logic        ready;
	logic [31:0] data_word;
	logic [2:0]  byte_count;
	logic        message_end;
	modport source (output valid, data_word, byte_count, message_end, input ready);
	modport sink (input valid, data_word, byte_count, message_end, output ready);
endinterface

interface sha_out_if;
	logic        valid;
	logic        ready;
	logic [31:0] digest_word;
	logic [2:0]  word_index;
	logic        last_word;
	modport source (output valid, digest_word, word_index, last_word, input ready);
	modport sink (input valid, digest_word, word_index, last_word, output ready);
endinterface

// ----- rtl/sha256_stream_hash.sv -----
// sha256_stream_hash: streaming SHA-256 top level, byte packer, padding and round sequencer.
// Depends on sha_pkg, sha_if, sha_buf, sha_hmem.
//
//   channel  | dir | payload                                  | transfer
//   in_ch    | in  | data_word, byte_count, message_end      | valid & ready
//   out_ch   | out | digest_word, word_index, last_word      | valid & ready
//
// Each item's bytes are packed into the block buffer; each full block then loads
// buffer and hash memory, runs 64 rounds and adds the result back into hash memory.
// Message end pushes the 0x80, zero and length pad bytes, then reads out each digest word.
// Reset clears control state; hash memory reads as initial values until written.
// A stalled digest word holds in the output register; new input is taken once
// the eighth word is loaded.
module sha256_stream_hash import sha_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	sha_in_if.sink    in_ch,
	sha_out_if.source out_ch
);
	localparam logic [2:0] ST_IDLE = 3'd0, ST_PUSH = 3'd1, ST_LOAD = 3'd2,
		ST_ROUND = 3'd3, ST_FIN = 3'd4, ST_DRD = 3'd5, ST_DCAP = 3'd6;
	localparam logic [2:0] PH_DATA = 3'd0, PH_80 = 3'd1, PH_ZERO = 3'd2,
		PH_LEN = 3'd3, PH_OUT = 3'd4;

	logic [2:0]  st_q, ph_q, bi_q, cnt_sat, oi_q;
	logic [31:0] data_q;
	logic [2:0]  count_q;
	logic        end_q;
	logic [5:0]  fill_q;
	logic [63:0] len_q;
	logic [4:0]  cnt_q;
	logic [5:0]  rnd_q;
	logic [31:0] v_q [8];
	logic [31:0] w_q [16];
	logic        out_valid_q;
	logic [31:0] out_data_q;
	logic [2:0]  out_idx_q;

	bf_ctl_t     bctl;
	hm_ctl_t     hctl;
	logic [7:0]  pbyte;
	logic        push;
	logic [31:0] brd, hrd, hwd;
	logic [31:0] big1, choose, t1, big0, major, t2, s0, s1, new_w;

	sha_buf u_buf (.clk(clk), .ctl(bctl), .wbyte(pbyte), .rdata(brd));
	sha_hmem u_hmem (.clk(clk), .arst_n(arst_n), .ctl(hctl), .wdata(hwd), .rdata(hrd));

	assign cnt_sat = (in_ch.byte_count > MaxBytes) ? MaxBytes : in_ch.byte_count;
	assign in_ch.ready = (st_q == ST_IDLE);

	always_comb begin
		push = 1'b0;
		pbyte = 8'h00;
		if (st_q == ST_PUSH) begin
			case (ph_q)
				PH_DATA: begin
					push = (bi_q < count_q);
					case (bi_q[1:0])
						2'd0: pbyte = data_q[31:24];
						2'd1: pbyte = data_q[23:16];
						2'd2: pbyte = data_q[15:8];
						default: pbyte = data_q[7:0];
					endcase
				end
				PH_80: begin
					push = 1'b1;
					pbyte = PadByte;
				end
				PH_ZERO: push = (fill_q != LenPos);
				PH_LEN: begin
					push = 1'b1;
					pbyte = 8'(len_q >> (7'd56 - {1'b0, bi_q, 3'b000}));
				end
				default: push = 1'b0;
			endcase
		end
	end

	always_comb begin
		bctl.we = push;
		bctl.waddr = fill_q[5:2];
		bctl.lane = fill_q[1:0];
		bctl.re = (st_q == ST_LOAD) && !cnt_q[4];
		bctl.raddr = cnt_q[3:0];
		hctl.we = (st_q == ST_FIN) && (cnt_q != 5'd0);
		hctl.waddr = 3'(cnt_q - 5'd1);
		hctl.clr = (st_q == ST_DCAP) && (oi_q == 3'd7);
		hctl.re = 1'b0;
		hctl.raddr = cnt_q[2:0];
		case (st_q)
			ST_LOAD, ST_FIN: hctl.re = (cnt_q < 5'd8);
			ST_DRD: begin
				hctl.re = !out_valid_q;
				hctl.raddr = oi_q;
			end
			default: hctl.re = 1'b0;
		endcase
	end

	assign hwd = hrd + v_q[0];

	always_comb begin
		big1 = rotr(v_q[4], 6) ^ rotr(v_q[4], 11) ^ rotr(v_q[4], 25);
		choose = (v_q[4] & v_q[5]) ^ (~v_q[4] & v_q[6]);
		t1 = v_q[7] + big1 + choose + RoundK[rnd_q] + w_q[0];
		big0 = rotr(v_q[0], 2) ^ rotr(v_q[0], 13) ^ rotr(v_q[0], 22);
		major = (v_q[0] & v_q[1]) ^ (v_q[0] & v_q[2]) ^ (v_q[1] & v_q[2]);
		t2 = big0 + major;
		s0 = rotr(w_q[1], 7) ^ rotr(w_q[1], 18) ^ (w_q[1] >> 3);
		s1 = rotr(w_q[14], 17) ^ rotr(w_q[14], 19) ^ (w_q[14] >> 10);
		new_w = w_q[0] + s0 + w_q[9] + s1;
	end

	always_ff @(posedge clk) begin
		if (in_ch.valid && in_ch.ready) begin
			data_q <= in_ch.data_word;
		end
		case (st_q)
			ST_LOAD: begin
				if (cnt_q != 5'd0) begin
					for (int j = 0; j < 15; j++) w_q[j] <= w_q[j + 1];
					w_q[15] <= brd;
				end
				if (cnt_q != 5'd0 && cnt_q <= 5'd8) begin
					for (int j = 0; j < 7; j++) v_q[j] <= v_q[j + 1];
					v_q[7] <= hrd;
				end
			end
			ST_ROUND: begin
				for (int j = 0; j < 15; j++) w_q[j] <= w_q[j + 1];
				w_q[15] <= new_w;
				v_q[7] <= v_q[6];
				v_q[6] <= v_q[5];
				v_q[5] <= v_q[4];
				v_q[4] <= v_q[3] + t1;
				v_q[3] <= v_q[2];
				v_q[2] <= v_q[1];
				v_q[1] <= v_q[0];
				v_q[0] <= t1 + t2;
			end
			ST_FIN: begin
				if (cnt_q != 5'd0) begin
					for (int j = 0; j < 7; j++) v_q[j] <= v_q[j + 1];
					v_q[7] <= v_q[0];
				end
			end
			ST_DCAP: out_data_q <= hrd;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
			ph_q <= PH_DATA;
			bi_q <= '0;
			count_q <= '0;
			end_q <= 1'b0;
			fill_q <= '0;
			len_q <= '0;
			cnt_q <= '0;
			rnd_q <= '0;
			oi_q <= '0;
			out_valid_q <= 1'b0;
			out_idx_q <= '0;
		end else begin
			if (out_valid_q && out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
			case (st_q)
				ST_IDLE: begin
					if (in_ch.valid) begin
						count_q <= cnt_sat;
						end_q <= in_ch.message_end;
						len_q <= len_q + {58'd0, cnt_sat, 3'b000};
						bi_q <= '0;
						ph_q <= PH_DATA;
						st_q <= ST_PUSH;
					end
				end
				ST_PUSH: begin
					case (ph_q)
						PH_DATA: begin
							if (bi_q < count_q) begin
								bi_q <= bi_q + 3'd1;
							end else if (end_q) begin
								ph_q <= PH_80;
							end else begin
								st_q <= ST_IDLE;
							end
						end
						PH_80: ph_q <= PH_ZERO;
						PH_ZERO: begin
							if (fill_q == LenPos) begin
								ph_q <= PH_LEN;
								bi_q <= '0;
							end
						end
						PH_LEN: begin
							bi_q <= bi_q + 3'd1;
							if (bi_q == 3'd7) ph_q <= PH_OUT;
						end
						default: begin
							st_q <= ST_DRD;
							oi_q <= '0;
							len_q <= '0;
							ph_q <= PH_DATA;
						end
					endcase
					if (push) begin
						fill_q <= fill_q + 6'd1;
						if (fill_q == 6'd63) begin
							st_q <= ST_LOAD;
							cnt_q <= '0;
						end
					end
				end
				ST_LOAD: begin
					cnt_q <= cnt_q + 5'd1;
					if (cnt_q == 5'd16) begin
						st_q <= ST_ROUND;
						rnd_q <= '0;
					end
				end
				ST_ROUND: begin
					rnd_q <= rnd_q + 6'd1;
					if (rnd_q == 6'd63) begin
						st_q <= ST_FIN;
						cnt_q <= '0;
					end
				end
				ST_FIN: begin
					cnt_q <= cnt_q + 5'd1;
					if (cnt_q == 5'd8) st_q <= ST_PUSH;
				end
				ST_DRD: begin
					if (!out_valid_q) st_q <= ST_DCAP;
				end
				ST_DCAP: begin
					out_valid_q <= 1'b1;
					out_idx_q <= oi_q;
					if (oi_q == 3'd7) begin
						st_q <= ST_IDLE;
					end else begin
						oi_q <= oi_q + 3'd1;
						st_q <= ST_DRD;
					end
				end
				default: st_q <= ST_IDLE;
			endcase
		end
	end

	assign out_ch.valid = out_valid_q;
	assign out_ch.digest_word = out_data_q;
	assign out_ch.word_index = out_idx_q;
	assign out_ch.last_word = (out_idx_q == 3'd7);

`ifndef SYNTHESIS
	a_round_to_fin: assert property (@(posedge clk) disable iff (!arst_n)
		(st_q == ST_ROUND && rnd_q == 6'd63) |=> st_q == ST_FIN)
		else $error("round count overran");
	a_load_on_full: assert property (@(posedge clk) disable iff (!arst_n)
		st_q == ST_LOAD |-> fill_q == 6'd0)
		else $error("block load with partial buffer");
	a_digest_clean: assert property (@(posedge clk) disable iff (!arst_n)
		st_q == ST_DRD |-> (fill_q == 6'd0 && len_q == 64'd0))
		else $error("digest read with stale length or fill");
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		st_q == ST_DCAP |-> !out_valid_q)
		else $error("digest word overwritten before transfer");
`endif
endmodule

// ----- rtl/sha_buf.sv -----
// sha_buf: 16 x 32-bit block buffer, byte-lane writes, registered read.
// Depends on sha_pkg.
module sha_buf import sha_pkg::*; (
	input  logic        clk,
	input  bf_ctl_t     ctl,
	input  logic [7:0]  wbyte,
	output logic [31:0] rdata
);
	logic [31:0] mem [16];
	logic [31:0] rd_q;

	always_ff @(posedge clk) begin
		for (int l = 0; l < 4; l++) begin
			if (ctl.we && ctl.lane == 2'(l)) begin
				mem[ctl.waddr][31 - 8 * l -: 8] <= wbyte;
			end
		end
		if (ctl.re) begin
			rd_q <= mem[ctl.raddr];
		end
	end

	assign rdata = rd_q;
endmodule

// ----- rtl/sha_hmem.sv -----
// sha_hmem: 8 x 32-bit hash word memory; entries not yet written read as the initial hash.
// Depends on sha_pkg.
module sha_hmem import sha_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  hm_ctl_t     ctl,
	input  logic [31:0] wdata,
	output logic [31:0] rdata
);
	logic [31:0] mem [8];
	logic [31:0] rd_q;
	logic [7:0]  vld_q;
	logic        rvld_q;
	logic [2:0]  raddr_q;

	always_ff @(posedge clk) begin
		if (ctl.we) begin
			mem[ctl.waddr] <= wdata;
		end
		if (ctl.re) begin
			rd_q <= mem[ctl.raddr];
			raddr_q <= ctl.raddr;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
			rvld_q <= 1'b0;
		end else begin
			if (ctl.re) begin
				rvld_q <= vld_q[ctl.raddr];
			end
			if (ctl.clr) begin
				vld_q <= '0;
			end else if (ctl.we) begin
				vld_q[ctl.waddr] <= 1'b1;
			end
		end
	end

	assign rdata = rvld_q ? rd_q : InitHash[raddr_q];
endmodule
